// ===== hw/rtl/npst_pkg.sv =====
// Shared types, defaults and command codes for the snap point table.
package npst_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int COORD_BITS_DEF  = 24;
	localparam int OWNER_BITS_DEF  = 16;
	localparam int CMD_W           = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_CLEAR   = 3'd2,
		CMD_NEAREST = 3'd3,
		CMD_RANGE   = 3'd4
	} cmd_t;

	typedef struct packed {
		logic ld;
		logic sh;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/nearest_point_snap_table_core.sv =====
// Snap point table: a ring of cells holding 3D points, with nearest and range search.
//
// Slave beats carry a command in s_tuser and a point, owner and limit in s_tdata.
// Master beats carry a point and the fill count in m_tdata, found and status in
// m_tuser, and the final beat of a command in m_tlast.
// One command is taken at a time; s_tready is high only while the block is idle.
// Add, clear and undefined commands go to the finish state, which raises m_tvalid.
// Nearest and range rotate the whole ring once through a three-stage squared
// distance unit at the head cell.
// Range gives one beat per point within the limit in table order, else a not-found beat.
// Remove marks the owner's cells, then drops one marked cell a cycle by shifting the
// cells above it down.
// s_tready rises with the final beat.
// A single output register parts the sides; when the receiver stalls, the ring and
// the distance pipeline hold until the waiting beat is taken.
// Reset empties the table and clears all control state; cell contents are not
// cleared, and are never read beyond the fill count.
module nearest_point_snap_table_core #(
	parameter int TABLE_DEPTH = npst_pkg::TABLE_DEPTH_DEF,
	parameter int COORD_BITS  = npst_pkg::COORD_BITS_DEF,
	parameter int OWNER_BITS  = npst_pkg::OWNER_BITS_DEF,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int IN_W  = ((4*COORD_BITS + OWNER_BITS - 1 + 7) / 8) * 8,
	localparam int OUT_W = ((3*COORD_BITS + CNT_W + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [IN_W-1:0]              s_tdata,  // coord_x, coord_y, coord_z, owner_id, limit
	input  logic [npst_pkg::CMD_W-1:0]   s_tuser,  // cmd
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [OUT_W-1:0]             m_tdata,  // res_x, res_y, res_z, count
	output logic [1:0]                   m_tuser,  // found, status
	output logic                         m_tlast
);
	import npst_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int EW = 3*CW + OWNER_BITS;
	localparam int SW = 2*CW + 4;
	localparam int LW = 2*CW - 2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_REM  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t st_q;

	logic signed [CW-1:0]   in_x, in_y, in_z;
	logic [OWNER_BITS-1:0]  in_own;
	logic [CW-2:0]          in_lim;
	logic                   acc, adv, beat_out;

	logic [CMD_W-1:0]       cmd_q;
	logic signed [CW-1:0]   qx_q, qy_q, qz_q;
	logic [LW-1:0]          lsq_q;
	logic [CNT_W-1:0]       fill_q, iss_q;
	logic                   status_q;
	logic [TABLE_DEPTH-1:0] mark_q, mark_nb, pre;

	logic [EW-1:0]          ent [TABLE_DEPTH];
	logic [EW-1:0]          nb  [TABLE_DEPTH];
	cell_ctl_t              ctl [TABLE_DEPTH];
	logic [EW-1:0]          in_entry;

	logic                   d_v, d_busy, issue;
	logic [SW-1:0]          d_sum;
	logic signed [CW-1:0]   d_x, d_y, d_z;
	logic                   hit;

	logic                   have_q, pend_q;
	logic [SW-1:0]          best_q;
	logic signed [CW-1:0]   bx_q, by_q, bz_q;

	logic                   ovalid_q, ofound_q, olast_q, ostat_q;
	logic signed [CW-1:0]   ox_q, oy_q, oz_q;
	logic [CNT_W-1:0]       ocnt_q;

	assign in_x     = s_tdata[CW-1:0];
	assign in_y     = s_tdata[2*CW-1:CW];
	assign in_z     = s_tdata[3*CW-1:2*CW];
	assign in_own   = s_tdata[3*CW+OWNER_BITS-1:3*CW];
	assign in_lim   = s_tdata[4*CW+OWNER_BITS-2:3*CW+OWNER_BITS];
	assign in_entry = {in_own, in_z, in_y, in_x};

	assign s_tready = (st_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign adv      = !ovalid_q || m_tready;
	assign issue    = (st_q == ST_SCAN) && adv && (iss_q < CNT_W'(TABLE_DEPTH));

	always_comb begin
		pre[0] = mark_q[0];
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			pre[i] = pre[i-1] | mark_q[i];
		end
	end
	assign mark_nb = {1'b0, mark_q[TABLE_DEPTH-1:1]};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_wrap
			assign nb[i] = ent[0];
		end else begin : g_mid
			assign nb[i] = ent[i+1];
		end
		assign ctl[i].ld = acc && (s_tuser == CMD_ADD) && (fill_q == CNT_W'(i));
		assign ctl[i].sh = issue || ((st_q == ST_REM) && pre[i]);
		npst_cell #(.EW(EW)) u_cell (
			.clk     (clk),
			.ctl     (ctl[i]),
			.ld_data (in_entry),
			.nb_data (nb[i]),
			.q       (ent[i])
		);
	end

	npst_dist #(.CW(CW)) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_v   (issue && (iss_q < fill_q)),
		.px     (ent[0][CW-1:0]),
		.py     (ent[0][2*CW-1:CW]),
		.pz     (ent[0][3*CW-1:2*CW]),
		.qx     (qx_q),
		.qy     (qy_q),
		.qz     (qz_q),
		.out_v  (d_v),
		.d      (d_sum),
		.ox     (d_x),
		.oy     (d_y),
		.oz     (d_z),
		.busy   (d_busy)
	);

	assign hit = d_sum < SW'(lsq_q);

	// final beat of a command, or a range hit that flushes the previous one
	assign beat_out = adv && ((st_q == ST_FIN) ||
		((st_q == ST_SCAN) && d_v && (cmd_q != CMD_NEAREST) && hit && pend_q));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			fill_q   <= '0;
			iss_q    <= '0;
			mark_q   <= '0;
			have_q   <= 1'b0;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (adv) begin
				ovalid_q <= beat_out;
			end
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						have_q <= 1'b0;
						pend_q <= 1'b0;
						iss_q  <= '0;
						for (int i = 0; i < TABLE_DEPTH; i++) begin
							mark_q[i] <= (ent[i][EW-1:3*CW] == in_own) && (CNT_W'(i) < fill_q);
						end
						case (s_tuser)
							CMD_ADD: begin
								if (fill_q < CNT_W'(TABLE_DEPTH)) begin
									fill_q <= fill_q + CNT_W'(1);
								end
								st_q <= ST_FIN;
							end
							CMD_REMOVE:  st_q <= ST_REM;
							CMD_CLEAR: begin
								fill_q <= '0;
								st_q   <= ST_FIN;
							end
							CMD_NEAREST: st_q <= ST_SCAN;
							CMD_RANGE:   st_q <= ST_SCAN;
							default:     st_q <= ST_FIN;
						endcase
					end
				end
				ST_REM: begin
					if (|mark_q) begin
						for (int i = 0; i < TABLE_DEPTH; i++) begin
							if (pre[i]) begin
								mark_q[i] <= mark_nb[i];
							end
						end
						fill_q <= fill_q - CNT_W'(1);
					end else begin
						st_q <= ST_FIN;
					end
				end
				ST_SCAN: begin
					if (adv) begin
						if (issue) begin
							iss_q <= iss_q + CNT_W'(1);
						end
						if (d_v) begin
							if (cmd_q == CMD_NEAREST) begin
								if (!have_q || d_sum < best_q) begin
									have_q <= 1'b1;
								end
							end else if (hit) begin
								pend_q <= 1'b1;
							end
						end
						if (!issue && !d_busy) begin
							st_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (adv) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// command, best point and output payload
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q    <= s_tuser;
			qx_q     <= in_x;
			qy_q     <= in_y;
			qz_q     <= in_z;
			lsq_q    <= LW'(in_lim) * LW'(in_lim);
			status_q <= (s_tuser == CMD_ADD) && (fill_q >= CNT_W'(TABLE_DEPTH));
		end
		if (st_q == ST_SCAN && adv && d_v) begin
			if (cmd_q == CMD_NEAREST) begin
				if (!have_q || d_sum < best_q) begin
					best_q <= d_sum;
					bx_q   <= d_x;
					by_q   <= d_y;
					bz_q   <= d_z;
				end
			end else if (hit) begin
				bx_q <= d_x;
				by_q <= d_y;
				bz_q <= d_z;
				if (pend_q) begin
					ox_q     <= bx_q;
					oy_q     <= by_q;
					oz_q     <= bz_q;
					ofound_q <= 1'b1;
					olast_q  <= 1'b0;
					ostat_q  <= 1'b0;
					ocnt_q   <= fill_q;
				end
			end
		end
		if (st_q == ST_FIN && adv) begin
			ocnt_q  <= fill_q;
			olast_q <= 1'b1;
			ostat_q <= status_q;
			if ((cmd_q == CMD_NEAREST && have_q && best_q < SW'(lsq_q)) ||
			    (cmd_q == CMD_RANGE && pend_q)) begin
				ox_q     <= bx_q;
				oy_q     <= by_q;
				oz_q     <= bz_q;
				ofound_q <= 1'b1;
			end else begin
				ox_q     <= qx_q;
				oy_q     <= qy_q;
				oz_q     <= qz_q;
				ofound_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = OUT_W'({ocnt_q, oz_q, oy_q, ox_q});
	assign m_tuser  = {ostat_q, ofound_q};
	assign m_tlast  = olast_q;

endmodule

// ===== hw/rtl/npst_cell.sv =====
// One table cell: holds a point and its owner, loads a new entry or takes its neighbour's.
module npst_cell #(
	parameter int EW = 88
) (
	input  logic               clk,
	input  npst_pkg::cell_ctl_t ctl,
	input  logic [EW-1:0]      ld_data,
	input  logic [EW-1:0]      nb_data,
	output logic [EW-1:0]      q
);
	import npst_pkg::*;

	logic [EW-1:0] ent_q;

	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			ent_q <= ld_data;
		end else if (ctl.sh) begin
			ent_q <= nb_data;
		end
	end

	assign q = ent_q;

endmodule

// ===== hw/rtl/npst_dist.sv =====
// Three-stage squared distance unit fed from the head cell of the table.
module npst_dist #(
	parameter int CW = 24,
	localparam int SW = 2*CW+4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	input  logic signed [CW-1:0] pz,
	input  logic signed [CW-1:0] qx,
	input  logic signed [CW-1:0] qy,
	input  logic signed [CW-1:0] qz,
	output logic                 out_v,
	output logic [SW-1:0]        d,
	output logic signed [CW-1:0] ox,
	output logic signed [CW-1:0] oy,
	output logic signed [CW-1:0] oz,
	output logic                 busy
);
	import npst_pkg::*;

	logic signed [CW:0]   dx, dy, dz;
	logic                 v_s1, v_s2, v_s3;
	logic [CW:0]          ax_s1, ay_s1, az_s1;
	logic [2*CW+1:0]      sx_s2, sy_s2, sz_s2;
	logic [SW-1:0]        d_s3;
	logic signed [CW-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2, x_s3, y_s3, z_s3;

	assign dx = {px[CW-1], px} - {qx[CW-1], qx};
	assign dy = {py[CW-1], py} - {qy[CW-1], qy};
	assign dz = {pz[CW-1], pz} - {qz[CW-1], qz};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= dx[CW] ? -dx : dx;
			ay_s1 <= dy[CW] ? -dy : dy;
			az_s1 <= dz[CW] ? -dz : dz;
			x_s1  <= px;
			y_s1  <= py;
			z_s1  <= pz;
			sx_s2 <= (2*CW+2)'(ax_s1) * (2*CW+2)'(ax_s1);
			sy_s2 <= (2*CW+2)'(ay_s1) * (2*CW+2)'(ay_s1);
			sz_s2 <= (2*CW+2)'(az_s1) * (2*CW+2)'(az_s1);
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			z_s2  <= z_s1;
			d_s3  <= SW'(sx_s2) + SW'(sy_s2) + SW'(sz_s2);
			x_s3  <= x_s2;
			y_s3  <= y_s2;
			z_s3  <= z_s2;
		end
	end

	assign out_v = v_s3;
	assign d     = d_s3;
	assign ox    = x_s3;
	assign oy    = y_s3;
	assign oz    = z_s3;
	assign busy  = v_s1 | v_s2 | v_s3;

endmodule
